FILE: sv/scb_pkg.sv
// ----------------------------------------------------------------------------
// scb_pkg
// Shared types, register map and constants for the chunk boundary splitter.
// ----------------------------------------------------------------------------
package scb_pkg;

    // counter width for the chunk byte count
    localparam int CNT_W = 40;
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // result fields
    localparam int IDX_W = 32;
    localparam int LEN_W = 40;

    // result queue
    localparam int MAX_RES = 3;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // apb
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_SPLIT_MODE  = 2'd0,
        REG_BYTE_LIMIT  = 2'd1,
        REG_LINES       = 2'd2,
        REG_SEPARATOR   = 2'd3
    } t_reg_idx;

    localparam logic [1:0] MODE_BYTES   = 2'd0;
    localparam logic [1:0] MODE_LINES   = 2'd1;

    localparam logic [1:0]  RST_SPLIT_MODE = MODE_LINES;
    localparam logic [31:0] RST_BYTE_LIMIT = 32'd1024;
    localparam logic [31:0] RST_LINES      = 32'd1000;
    localparam logic [7:0]  RST_SEPARATOR  = 8'd10;

    typedef struct packed {
        logic [IDX_W-1:0] chunk_index;
        logic [LEN_W-1:0] chunk_length;
        logic             stream_done;
        logic             last_result;
    } t_result;

    // saturating add at the counter maximum
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W:0]   b);
        logic [CNT_W+1:0] s;
        s = {2'b00, a} + {1'b0, b};
        if (s > {2'b00, CNT_MAX}) begin
            return CNT_MAX;
        end
        return s[CNT_W-1:0];
    endfunction

endpackage

FILE: sv/stream_chunk_boundary_splitter.sv
// ----------------------------------------------------------------------------
// stream_chunk_boundary_splitter
// Tracks a byte stream and reports every closed chunk (index and length) in
// byte, record count or whole-record-up-to-limit mode.
// ----------------------------------------------------------------------------
//
//  channel   valid     stall     payload
//  -------   -------   -------   ---------------------------------------------
//  input     i_valid   o_stall   i_data_byte, i_end_of_input
//  result    o_valid   i_stall   o_chunk_index, o_chunk_length,
//                                o_stream_done, o_last_result
//  config    apb       -         psel, penable, pwrite, paddr, pwdata, prdata
//
//  One byte is taken per cycle while o_stall is low; its chunk decisions
//  settle in the same cycle and land in a 4-entry result queue, which
//  registers them. A byte that closes two or three chunks yields that
//  many results; the input stalls while the queue has fewer than 3 free
//  slots after this cycle's pop. Synchronous reset puts the counters at
//  zero and the registers at their reset values; no clearing pass is needed.
//
module stream_chunk_boundary_splitter
    import scb_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // byte input
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_input,
    // chunk results
    output logic              o_valid,
    input  logic              i_stall,
    output logic [IDX_W-1:0]  o_chunk_index,
    output logic [LEN_W-1:0]  o_chunk_length,
    output logic              o_stream_done,
    output logic              o_last_result,
    // configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // configuration registers
    logic [1:0]  r_split_mode;
    logic [31:0] r_byte_limit;
    logic [31:0] r_lines;
    logic [7:0]  r_separator;

    // stream state
    logic [CNT_W-1:0] r_chunk_fill,   n_chunk_fill;
    logic [32:0]      r_record_fill,  n_record_fill;
    logic [31:0]      r_records,      n_records;
    logic [IDX_W-1:0] r_next_index,   n_next_index;
    logic             r_long_record,  n_long_record;

    // result queue
    t_result          r_queue [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr;
    logic [Q_CW-1:0]  r_count;

    logic             cfg_wr;
    t_reg_idx         cfg_idx;
    logic             accept;
    logic             pop;
    logic [Q_CW-1:0]  occ_after_pop;

    logic             sep;
    logic [31:0]      lim;
    logic [CNT_W-1:0] cf_inc;
    logic [32:0]      rf_inc;
    logic [CNT_W-1:0] cf_sum;
    logic [1:0]       v_cnt;
    logic [LEN_W-1:0] v_len [MAX_RES];

    // ------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_SPLIT_MODE: prdata = {30'd0, r_split_mode};
            REG_BYTE_LIMIT: prdata = r_byte_limit;
            REG_LINES:      prdata = r_lines;
            REG_SEPARATOR:  prdata = {24'd0, r_separator};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_split_mode <= RST_SPLIT_MODE;
            r_byte_limit <= RST_BYTE_LIMIT;
            r_lines      <= RST_LINES;
            r_separator  <= RST_SEPARATOR;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_SPLIT_MODE: r_split_mode <= pwdata[1:0];
                REG_BYTE_LIMIT: r_byte_limit <= pwdata;
                REG_LINES:      r_lines      <= pwdata;
                REG_SEPARATOR:  r_separator  <= pwdata[7:0];
                default:        r_split_mode <= r_split_mode;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    assign o_valid       = (r_count != '0);
    assign pop           = o_valid && !i_stall;
    assign occ_after_pop = r_count - Q_CW'(pop);
    assign o_stall       = (occ_after_pop > Q_CW'(Q_DEPTH - MAX_RES));
    assign accept        = i_valid && !o_stall;

    assign o_chunk_index  = r_queue[r_rd_ptr].chunk_index;
    assign o_chunk_length = r_queue[r_rd_ptr].chunk_length;
    assign o_stream_done  = r_queue[r_rd_ptr].stream_done;
    assign o_last_result  = r_queue[r_rd_ptr].last_result;

    // ------------------------------------------------------------------
    // chunk decisions for one byte
    // ------------------------------------------------------------------
    assign sep    = (i_data_byte == r_separator);
    assign lim    = (r_byte_limit == '0) ? 32'd1 : r_byte_limit;
    assign cf_inc = sat_add(r_chunk_fill, (CNT_W+1)'(1));
    assign rf_inc = r_record_fill + 33'd1;

    always_comb begin
        n_chunk_fill  = r_chunk_fill;
        n_record_fill = r_record_fill;
        n_records     = r_records;
        n_long_record = r_long_record;
        v_cnt         = '0;
        cf_sum        = '0;
        for (int k = 0; k < MAX_RES; k++) begin
            v_len[k] = '0;
        end

        unique case (r_split_mode)
            MODE_BYTES: begin
                n_chunk_fill = cf_inc;
                if (cf_inc >= {8'd0, lim}) begin
                    v_len[v_cnt] = cf_inc;
                    v_cnt        = v_cnt + 2'd1;
                    n_chunk_fill = '0;
                    n_records    = '0;
                end
            end
            MODE_LINES: begin
                n_chunk_fill = cf_inc;
                if (sep) begin
                    if (r_records != '1) begin
                        n_records = r_records + 32'd1;
                    end
                    if (n_records >= r_lines) begin
                        v_len[v_cnt] = cf_inc;
                        v_cnt        = v_cnt + 2'd1;
                        n_chunk_fill = '0;
                        n_records    = '0;
                    end
                end
            end
            default: begin
                // whole records up to the byte limit
                n_record_fill = rf_inc;
                if (r_long_record) begin
                    if (rf_inc >= {1'b0, lim}) begin
                        v_len[v_cnt]  = {8'd0, lim};
                        v_cnt         = v_cnt + 2'd1;
                        n_record_fill = rf_inc - {1'b0, lim};
                    end
                end else if (rf_inc > {1'b0, lim}) begin
                    // record outgrows the limit: flush open chunk, cut a full one
                    if (r_chunk_fill != '0) begin
                        v_len[v_cnt] = r_chunk_fill;
                        v_cnt        = v_cnt + 2'd1;
                    end
                    n_chunk_fill  = '0;
                    n_records     = '0;
                    v_len[v_cnt]  = {8'd0, lim};
                    v_cnt         = v_cnt + 2'd1;
                    n_record_fill = rf_inc - {1'b0, lim};
                    n_long_record = 1'b1;
                end
                if (sep || i_end_of_input) begin
                    cf_sum = sat_add(n_chunk_fill, {8'd0, n_record_fill});
                    if (!n_long_record && (n_chunk_fill != '0) &&
                        (cf_sum > {8'd0, lim})) begin
                        v_len[v_cnt] = n_chunk_fill;
                        v_cnt        = v_cnt + 2'd1;
                        n_chunk_fill = '0;
                        n_records    = '0;
                    end
                    n_chunk_fill  = sat_add(n_chunk_fill, {8'd0, n_record_fill});
                    n_record_fill = '0;
                    n_long_record = 1'b0;
                end
            end
        endcase

        n_next_index = r_next_index + IDX_W'(v_cnt);
        if (i_end_of_input) begin
            if (n_chunk_fill != '0) begin
                v_len[v_cnt] = n_chunk_fill;
                v_cnt        = v_cnt + 2'd1;
            end
            n_chunk_fill  = '0;
            n_records     = '0;
            n_record_fill = '0;
            n_long_record = 1'b0;
            n_next_index  = '0;
        end
    end

    // ------------------------------------------------------------------
    // state and result queue
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk_fill  <= '0;
            r_record_fill <= '0;
            r_records     <= '0;
            r_next_index  <= '0;
            r_long_record <= 1'b0;
        end else if (accept) begin
            r_chunk_fill  <= n_chunk_fill;
            r_record_fill <= n_record_fill;
            r_records     <= n_records;
            r_next_index  <= n_next_index;
            r_long_record <= n_long_record;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_RES; k++) begin
                if (2'(k) < v_cnt) begin
                    r_queue[r_wr_ptr + Q_AW'(k)] <= '{
                        chunk_index:  r_next_index + IDX_W'(k),
                        chunk_length: v_len[k],
                        stream_done:  i_end_of_input && (2'(k) == v_cnt - 2'd1),
                        last_result:  (2'(k) == v_cnt - 2'd1)
                    };
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(v_cnt);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            r_count <= occ_after_pop + (accept ? Q_CW'(v_cnt) : Q_CW'(0));
        end
    end

endmodule
